/* design/dsfc_pkg.sv */
// Shared types, register indexes and a helper function for the stuffed frame builder.
// Used by every module of the block; depends on nothing else.
package dsfc_pkg;

    localparam int MAX_RESULTS = 7;
    localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_START_CHAR  = 2'd0;
    localparam cfg_idx_t CFG_END_CHAR    = 2'd1;
    localparam cfg_idx_t CFG_ESCAPE_CHAR = 2'd2;

    localparam logic [7:0] START_CHAR_RST  = 8'd15;
    localparam logic [7:0] END_CHAR_RST    = 8'd4;
    localparam logic [7:0] ESCAPE_CHAR_RST = 8'd5;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [7:0] start_ch;
        logic [7:0] end_ch;
        logic [7:0] escape_ch;
    } ctrl_chars_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
    } slot_t;

    typedef struct packed {
        slot_t [MAX_RESULTS-1:0] slots;
        slot_idx_t               last_idx;
    } burst_t;

    function automatic logic is_ctrl(input logic [7:0] b, input ctrl_chars_t c);
        return (b == c.start_ch) || (b == c.end_ch) || (b == c.escape_ch);
    endfunction

endpackage

/* design/dsfc_cfg.sv */
// Configuration registers: start, end and escape characters.
// Depends on dsfc_pkg.
module dsfc_cfg import dsfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [7:0]  cfg_data,
    output ctrl_chars_t chars
);

    ctrl_chars_t chars_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg.start_ch  <= START_CHAR_RST;
            chars_reg.end_ch    <= END_CHAR_RST;
            chars_reg.escape_ch <= ESCAPE_CHAR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_CHAR:  chars_reg.start_ch  <= cfg_data;
                CFG_END_CHAR:    chars_reg.end_ch    <= cfg_data;
                CFG_ESCAPE_CHAR: chars_reg.escape_ch <= cfg_data;
                default: ;
            endcase
        end
    end

    assign chars = chars_reg;

endmodule

/* design/dsfc_build.sv */
// Expands one message byte into its burst of framed output bytes and keeps the running sum.
// Depends on dsfc_pkg.
module dsfc_build import dsfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  item_t       item,
    input  logic        load,
    input  ctrl_chars_t chars,
    output burst_t      burst
);

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] sum_acc;
    logic [7:0] cks;
    slot_idx_t  idx;

    always_comb begin
        sum_acc = (item.first_byte ? 8'd0 : running_sum_reg) + item.data_byte;
        cks     = 8'd0 - sum_acc;
        burst   = '0;
        idx     = '0;

        if (item.first_byte) begin
            burst.slots[idx] = '{value: chars.start_ch, frame_end: 1'b0};
            idx = idx + 1'b1;
            burst.slots[idx] = '{value: chars.start_ch, frame_end: 1'b0};
            idx = idx + 1'b1;
        end
        if (is_ctrl(item.data_byte, chars)) begin
            burst.slots[idx] = '{value: chars.escape_ch, frame_end: 1'b0};
            idx = idx + 1'b1;
        end
        burst.slots[idx] = '{value: item.data_byte, frame_end: 1'b0};
        idx = idx + 1'b1;

        // The checksum trails the last byte and is stuffed like payload.
        if (item.last_byte) begin
            if (is_ctrl(cks, chars)) begin
                burst.slots[idx] = '{value: chars.escape_ch, frame_end: 1'b0};
                idx = idx + 1'b1;
            end
            burst.slots[idx] = '{value: cks, frame_end: 1'b0};
            idx = idx + 1'b1;
            burst.slots[idx] = '{value: chars.end_ch, frame_end: 1'b1};
            idx = idx + 1'b1;
        end

        burst.last_idx   = idx - 1'b1;
        running_sum_next = item.last_byte ? 8'd0 : sum_acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= 8'd0;
        end else if (load) begin
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

/* design/dsfc_emit.sv */
// Holds one expanded burst; sends it out one word per cycle while m_tready is high.
// Depends on dsfc_pkg.
module dsfc_emit import dsfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  burst_t     burst,
    input  logic       load,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // frame_end
    output logic       m_tlast    // run_last
);

    burst_t    burst_reg;
    logic      valid_reg;
    slot_idx_t pos_reg;
    logic      at_last;

    assign at_last = (pos_reg == burst_reg.last_idx);
    // The burst register can take a new burst in the cycle its last word leaves.
    assign free    = !valid_reg || (m_tready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            pos_reg <= pos_reg + 1'b1;
            if (at_last) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = burst_reg.slots[pos_reg].value;
    assign m_tuser  = burst_reg.slots[pos_reg].frame_end;
    assign m_tlast  = at_last;

endmodule

/* design/dle_stuffed_frame_with_checksum.sv */
// Byte-stuffed frame builder with a two's complement checksum.
//
// The slave side takes one message byte per word, with tuser marking the
// first byte of a message and tlast the last one. The master side sends the
// framed stream one byte per word: tuser is high on the closing end character
// and tlast on the final word produced by each input word.
// A first byte is preceded by two start characters. Any data or checksum byte
// equal to a control character is preceded by the escape character. A last
// byte is followed by the checksum and the end character.
// The cfg channel writes the start (index 0), end (1) and escape (2)
// characters; it is always ready and is meant to be written while idle.
//
// Each item passes through the input register and then the burst register
// before its first output word is presented. The output sends one word per
// cycle while m_tready is high, so throughput is set by the number of words,
// one to seven, that the item expands to; items that expand to a single word
// flow at one per cycle while the master side is ready.
// An input register ahead of the burst register lets the next item be taken
// while the master side stalls. When the receiver stalls, the current word
// holds and the input stops once the input register is full.
// Reset clears the running sum, restores the default characters and empties
// both registers.
module dle_stuffed_frame_with_checksum import dsfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // first_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // frame_end
    output logic       m_tlast,   // run_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_idx_t   cfg_index,
    input  logic [7:0] cfg_data
);

    ctrl_chars_t chars;
    item_t       in_item_reg;
    logic        in_valid_reg;
    logic        load;
    logic        free;
    burst_t      burst;

    assign cfg_ready = 1'b1;
    assign load      = in_valid_reg && free;
    assign s_tready  = !in_valid_reg || free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{data_byte: s_tdata, first_byte: s_tuser, last_byte: s_tlast};
        end
    end

    dsfc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (chars)
    );

    dsfc_build u_build (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .load    (load),
        .chars   (chars),
        .burst   (burst)
    );

    dsfc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .burst    (burst),
        .load     (load),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/dsfc_checker.sv */
// Port-level checks for the stuffed frame builder, bound to the top level.
// Depends on dsfc_pkg and dle_stuffed_frame_with_checksum.
module dsfc_checker import dsfc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled output word keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output word changed");

    // The end character always closes the burst of its input word.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end not on the last word of a burst");

    // Reset leaves no output pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // With nothing pending on the output, the input side must be open.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input blocked while the block is empty");

endmodule

bind dle_stuffed_frame_with_checksum dsfc_checker u_dsfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
